// ----- hw/rtl/pph_pkg.sv -----
// Shared types and constants for the perturb-probe hash table.
package pph_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam int unsigned PROBE_EXTRA = 13;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_CHECK   = 14'b00000000000010,
    S_PROBE   = 14'b00000000000100,
    S_PWAIT   = 14'b00000000001000,
    S_PEVAL   = 14'b00000000010000,
    S_KWAIT   = 14'b00000000100000,
    S_KEVAL   = 14'b00000001000000,
    S_FINISH  = 14'b00000010000000,
    S_LASTRD  = 14'b00000100000000,
    S_LASTWT  = 14'b00001000000000,
    S_CLEAR   = 14'b00010000000000,
    S_RHRD    = 14'b00100000000000,
    S_RHWT    = 14'b01000000000000,
    S_OUT     = 14'b10000000000000
  } state_t;

  // What the current probe walk is searching for.
  typedef enum logic [2:0] {
    W_KEY   = 3'b001,
    W_LAST  = 3'b010,
    W_EMPTY = 3'b100
  } walk_t;

endpackage

// ----- hw/rtl/pph_ram.sv -----
// Generic single-port RAM with registered read.
module pph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- hw/rtl/perturb_probe_hash_table_core.sv -----
// Top level of the perturb-probe open-addressing hash table.
// Each visited slot is read through S_PROBE, S_PWAIT and S_PEVAL, and each key compare goes through
// S_KWAIT and S_KEVAL; the result is offered in S_OUT, and a delete adds a walk for the last entry
// plus its copy through S_LASTRD and S_LASTWT. A search stops after slots + 13 probes; one
// operation is in flight at a time. Growth costs a clearing sweep over all MAX_SLOTS slots plus
// one re-probe walk per live entry; reset (rst, synchronous) runs the sweep.
module perturb_probe_hash_table_core
  import pph_pkg::*;
#(
  parameter int MIN_SLOTS    = 16,
  parameter int MAX_SLOTS    = 256,
  parameter int KEY_BITS     = 64,
  parameter int PERTURB_BITS = 5
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // op[1:0], key[65:2], key_hash[129:66], value[193:130], zero pad to 200
  input  logic [199:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], found[2], read_value[66:3], entry_count[75:67], zero pad to 80
  output logic [79:0]  m_tdata
);
  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = AW + 1;               // counts 0..MAX_SLOTS
  localparam int LW = $clog2(AW + 1) + 1;   // capacity log
  localparam int SW = CW + 1;               // slot word: entry index or marks
  localparam logic [SW-1:0] SLOT_EMPTY = {SW{1'b1}};
  localparam logic [SW-1:0] SLOT_TOMB  = {{(SW-1){1'b1}}, 1'b0};
  localparam int PW = CW + 1;               // probe step counter
  localparam logic [LW-1:0] MIN_LOG = LW'($clog2(MIN_SLOTS));
  localparam logic [LW-1:0] MAX_LOG = LW'($clog2(MAX_SLOTS));

  state_t state;
  walk_t  walk;

  // Operation registers.
  logic [1:0]  op;
  logic [63:0] key, hsh, val;
  logic [1:0]  status;
  logic        found;
  logic [63:0] rval;

  logic [CW-1:0] live;
  logic [LW-1:0] clog;
  logic [CW-1:0] slots;
  logic [AW-1:0] mask;
  assign slots = CW'(1) << clog;
  assign mask  = AW'(slots - CW'(1));

  // Probe walker state.
  logic [AW-1:0] pos;
  logic [63:0]   perturb;
  logic [PW-1:0] steps;
  logic          have_free;
  logic [AW-1:0] fslot;
  logic [63:0]   wkey;     // key being searched
  logic [CW-1:0] went;     // entry index being placed (rehash) or hit entry
  logic [AW-1:0] hslot;    // hit slot of the deleted key
  logic [CW-1:0] hent;
  logic [AW-1:0] sweep;
  logic [CW-1:0] rhe;      // rehash entry index
  logic          after_rh; // rehash was triggered by an insert

  // Slot RAM.
  logic          s_we;
  logic [AW-1:0] s_addr;
  logic [SW-1:0] s_wd, s_rd;
  pph_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_slot (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));

  // Entry RAM: key, value and hash in one word.
  logic           e_we;
  logic [AW-1:0]  e_addr;
  logic [191:0]   e_wd, e_rd;
  pph_ram #(.WIDTH(192), .DEPTH(MAX_SLOTS)) u_ent (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wd), .rdata(e_rd));

  logic [63:0] kmask;
  assign kmask = (KEY_BITS >= 64) ? {64{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);

  logic [AW-1:0] npos;
  assign npos = AW'((pos * AW'(5)) + AW'(1) + perturb[AW-1:0]) & mask;

  logic [CW-1:0] s_idx;
  assign s_idx = s_rd[CW-1:0];
  logic s_is_ent;
  assign s_is_ent = (s_rd != SLOT_EMPTY) && (s_rd != SLOT_TOMB) && (s_rd[SW-1] == 1'b0)
                    && (s_idx < live);
  logic cap_hit;
  assign cap_hit = (steps + PW'(1)) >= (PW'(slots) + PW'(PROBE_EXTRA));

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {4'd0, live, rval, found, status};

  // Single-driver combinational RAM controls.
  always_comb begin
    s_we = 1'b0; s_addr = pos; s_wd = SLOT_EMPTY;
    e_we = 1'b0; e_addr = went[AW-1:0]; e_wd = e_rd;
    unique case (state)
      S_CLEAR: begin s_we = 1'b1; s_addr = sweep; s_wd = SLOT_EMPTY; end
      S_PROBE: s_addr = pos;
      S_PEVAL: begin
        s_addr = pos;
        if (walk == W_EMPTY && s_rd == SLOT_EMPTY) begin
          s_we = 1'b1; s_wd = SW'(went);
        end
      end
      S_KWAIT, S_KEVAL: e_addr = s_idx[AW-1:0];
      S_RHRD, S_RHWT: e_addr = rhe[AW-1:0];
      S_LASTRD, S_LASTWT: e_addr = AW'(live - CW'(1));
      S_FINISH: begin
        if (op == OP_INSERT && !found && status == ST_OK) begin
          s_we = 1'b1; s_addr = fslot; s_wd = SW'(live);
          e_we = 1'b1; e_addr = live[AW-1:0]; e_wd = {hsh, val, key};
        end else if (op == OP_INSERT && found) begin
          e_we = 1'b1; e_addr = hent[AW-1:0]; e_wd = {e_rd[191:128], val, e_rd[63:0]};
        end else if (op == OP_DELETE && found) begin
          s_we = 1'b1; s_addr = hslot; s_wd = SLOT_TOMB;
        end
      end
      default: ;
    endcase
    // The first slot whose entry holds the last key is pointed at the hole.
    if (state == S_KEVAL && walk == W_LAST && e_rd[63:0] == wkey) begin
      s_we = 1'b1; s_wd = SW'(hent);
    end
    if (state == S_LASTWT && walk == W_LAST) begin
      e_we = 1'b1; e_addr = hent[AW-1:0]; e_wd = e_rd;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; sweep <= '0; live <= '0; clog <= MIN_LOG;
      after_rh <= 1'b0; walk <= W_KEY;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          op <= s_tdata[1:0]; key <= s_tdata[65:2] & kmask;
          hsh <= s_tdata[129:66]; val <= s_tdata[193:130];
          status <= ST_NOT_FOUND; found <= 1'b0; rval <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          wkey <= key; walk <= W_KEY; perturb <= hsh; pos <= AW'(hsh) & mask;
          steps <= '0; have_free <= 1'b0;
          if (op == OP_INSERT && ({live, 2'b0} >= (CW+2)'(slots) * (CW+2)'(3))
              && clog < MAX_LOG) begin
            clog <= clog + LW'(1); sweep <= '0; after_rh <= 1'b1; state <= S_CLEAR;
          end else if (op == OP_INSERT && live >= slots) begin
            status <= ST_FULL; state <= S_OUT;
          end else if (op == OP_INSERT || op == OP_LOOKUP || op == OP_DELETE) begin
            state <= S_PROBE;
          end else state <= S_OUT;
        end
        S_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(MAX_SLOTS - 1)) begin
            rhe <= '0;
            state <= (after_rh && live != '0) ? S_RHRD : (after_rh ? S_CHECK : S_IDLE);
            if (after_rh && live == '0) after_rh <= 1'b0;
          end
        end
        S_RHRD: state <= S_RHWT;
        S_RHWT: begin
          walk <= W_EMPTY; went <= rhe; perturb <= e_rd[191:128];
          pos <= AW'(e_rd[191:128]) & mask; steps <= '0; state <= S_PROBE;
        end
        S_PROBE: state <= S_PWAIT;
        S_PWAIT: state <= S_PEVAL;
        S_PEVAL: begin
          if (walk == W_EMPTY) begin
            if (s_rd == SLOT_EMPTY || cap_hit) begin
              if (rhe + CW'(1) >= live) begin after_rh <= 1'b0; state <= S_CHECK; end
              else begin rhe <= rhe + CW'(1); state <= S_RHRD; end
            end else begin
              pos <= npos; perturb <= perturb >> PERTURB_BITS; steps <= steps + PW'(1);
              state <= S_PROBE;
            end
          end else if (s_rd == SLOT_EMPTY) begin
            if (!have_free) begin have_free <= 1'b1; fslot <= pos; end
            if (walk == W_LAST) state <= S_LASTRD;
            else begin
              if (op == OP_INSERT && live < CW'(MAX_SLOTS)) status <= ST_OK;
              else if (op == OP_INSERT) status <= ST_FULL;
              state <= S_FINISH;
            end
          end else if (s_is_ent) begin
            state <= S_KWAIT;
          end else begin
            if (s_rd == SLOT_TOMB && !have_free) begin have_free <= 1'b1; fslot <= pos; end
            if (cap_hit) begin
              if (walk == W_LAST) state <= S_LASTRD;
              else begin
                if (op == OP_INSERT)
                  status <= (have_free || s_rd == SLOT_TOMB) && live < CW'(MAX_SLOTS)
                            ? ST_OK : ST_FULL;
                state <= S_FINISH;
              end
            end else begin
              pos <= npos; perturb <= perturb >> PERTURB_BITS; steps <= steps + PW'(1);
              state <= S_PROBE;
            end
          end
        end
        S_KWAIT: state <= S_KEVAL;
        S_KEVAL: begin
          if (e_rd[63:0] == wkey) begin
            if (walk == W_LAST) state <= S_LASTRD;
            else begin
              found <= 1'b1; status <= ST_OK; hslot <= pos; hent <= s_idx;
              if (op == OP_LOOKUP) rval <= e_rd[127:64];
              if (op == OP_DELETE) state <= S_LASTRD;
              else begin went <= s_idx; state <= S_FINISH; end
            end
          end else if (cap_hit) begin
            if (walk == W_LAST) state <= S_LASTRD;
            else begin
              if (op == OP_INSERT)
                status <= have_free && live < CW'(MAX_SLOTS) ? ST_OK : ST_FULL;
              state <= S_FINISH;
            end
          end else begin
            pos <= npos; perturb <= perturb >> PERTURB_BITS; steps <= steps + PW'(1);
            state <= S_PROBE;
          end
        end
        S_LASTRD: state <= S_LASTWT;
        S_LASTWT: begin
          if (walk == W_KEY) begin
            // Walk for the last entry; its slot is redirected on the hit.
            walk <= W_LAST; wkey <= e_rd[63:0]; perturb <= e_rd[191:128];
            pos <= AW'(e_rd[191:128]) & mask; steps <= '0; state <= S_PROBE;
          end else begin
            // The last entry is copied into the hole in this state.
            walk <= W_KEY; state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (op == OP_INSERT && !found && status == ST_OK) live <= live + CW'(1);
          if (op == OP_DELETE && found) live <= live - CW'(1);
          if (op == OP_INSERT && !found && status == ST_NOT_FOUND) status <= ST_FULL;
          state <= S_OUT;
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result is never offered while an input beat can be taken.
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("ready and valid high together");
  // The live count never exceeds the current slot count.
  a_live: assert property (@(posedge clk) disable iff (rst) live <= slots)
    else $error("live count above slot count");
  // Found results always report success.
  a_found: assert property (@(posedge clk) disable iff (rst) (m_tvalid && found)
    |-> status == ST_OK) else $error("found without success");
  // The capacity stays within its configured bounds.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    clog >= MIN_LOG && clog <= MAX_LOG) else $error("capacity out of range");
endmodule
